// ===== design/obd_mode01_hex_response_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef OBD_MODE01_HEX_RESPONSE_DECODER_ASSERT_SVH
`define OBD_MODE01_HEX_RESPONSE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obd decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obd decoder: next-cycle check failed");

`endif

// ===== design/obd_pkg.sv =====
package obd_pkg;

  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned KEPT_W      = $clog2(STORE_DEPTH + 1);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] MODE01_REPLY = 8'h41;
  localparam logic [7:0] PID_RPM      = 8'h0C;
  localparam logic [7:0] PID_SPEED    = 8'h0D;
  localparam logic [7:0] PID_COOLANT  = 8'h05;
  localparam logic [7:0] PID_THROTTLE = 8'h11;
  localparam logic [7:0] PID_FUEL     = 8'h2F;

  localparam logic [14:0] COOLANT_OFFSET = 15'd40;
  localparam logic [14:0] PERCENT_SCALE  = 15'd100;

  typedef enum logic [2:0] {
    QTY_RPM      = 3'd0,
    QTY_SPEED    = 3'd1,
    QTY_COOLANT  = 3'd2,
    QTY_THROTTLE = 3'd3,
    QTY_FUEL     = 3'd4
  } qty_t;

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] to_nibble(input logic [7:0] ch);
    logic [4:0] res;
    case (ch) inside
      [8'h30:8'h39]: res = {1'b0, ch[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: res = {1'b0, 4'(ch[3:0] + 4'd9)};
      default:       res = 5'h10;
    endcase
    return res;
  endfunction

  // Exact floor(x / 255) for every 15-bit x.
  function automatic logic [7:0] div255(input logic [14:0] x);
    logic [15:0] s;
    s = {1'b0, x} + {9'd0, x[14:8]} + 16'd1;
    return s[15:8];
  endfunction

endpackage

// ===== design/obd_mode01_hex_response_decoder.sv =====
// Latency: a result is registered at the edge that accepts the last character
//   of a reply and is shown from the following cycle.
// Throughput: one character per cycle; a waiting result blocks input only
//   while out_ready is low.
// Reset: rst_n clears the kept count, end-of-string flag and result valid;
//   the nibble store is not cleared.
module obd_mode01_hex_response_decoder
  import obd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_character,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [2:0]         out_quantity,
  output logic signed [14:0] out_value
);

`include "obd_mode01_hex_response_decoder_assert.svh"

  logic [4:0]        store_r [STORE_DEPTH];
  logic [KEPT_W-1:0] kept_count_r, kept_count_nxt;
  logic              string_ended_r, string_ended_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  qty_t               out_qty_r, out_qty_nxt;
  logic signed [14:0] out_value_r, out_value_nxt;

  logic              in_acc, is_ws, keep, wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [4:0]        nib;
  logic [KEPT_W-1:0] kept_cur;
  logic [4:0]        view [STORE_DEPTH];

  logic [7:0]  byte0, byte1, byte_a, byte_b;
  logic        bad0, bad1, bad_a, bad_b, hdr_ok;
  logic [14:0] pct_prod;
  logic        dec_ok;
  qty_t        dec_qty;
  logic signed [14:0] dec_value;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    is_ws  = (in_character == CHAR_SPACE) || (in_character == CHAR_CR) ||
             (in_character == CHAR_LF);
    keep   = in_acc && !string_ended_r && (in_character != CHAR_NUL) && !is_ws;
    // Drop kept characters beyond the store; they only saturate the count.
    wr_en  = keep && (kept_count_r < KEPT_W'(STORE_DEPTH));
    wr_idx = kept_count_r[IDX_W-1:0];
    nib    = to_nibble(in_character);
    kept_cur = wr_en ? KEPT_W'(kept_count_r + 1'b1) : kept_count_r;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = (wr_en && (wr_idx == IDX_W'(i))) ? nib : store_r[i];
    end
  end

  // Decode from the store as it stands after this character.
  always_comb begin
    byte0  = {view[0][3:0], view[1][3:0]};
    byte1  = {view[2][3:0], view[3][3:0]};
    byte_a = {view[4][3:0], view[5][3:0]};
    byte_b = {view[6][3:0], view[7][3:0]};
    bad0   = view[0][4] | view[1][4];
    bad1   = view[2][4] | view[3][4];
    bad_a  = view[4][4] | view[5][4];
    bad_b  = view[6][4] | view[7][4];
    hdr_ok = (kept_cur >= KEPT_W'(4)) && !bad0 && !bad1 && (byte0 == MODE01_REPLY);
    pct_prod  = {7'd0, byte_a} * PERCENT_SCALE;
    dec_ok    = 1'b0;
    dec_qty   = QTY_RPM;
    dec_value = '0;
    if (hdr_ok) begin
      case (byte1)
        PID_RPM: begin
          if ((kept_cur >= KEPT_W'(8)) && !bad_a && !bad_b) begin
            dec_ok    = 1'b1;
            dec_qty   = QTY_RPM;
            dec_value = {1'b0, byte_a, byte_b[7:2]};
          end
        end
        PID_SPEED: begin
          if ((kept_cur >= KEPT_W'(6)) && !bad_a) begin
            dec_ok    = 1'b1;
            dec_qty   = QTY_SPEED;
            dec_value = {7'd0, byte_a};
          end
        end
        PID_COOLANT: begin
          if ((kept_cur >= KEPT_W'(6)) && !bad_a) begin
            dec_ok    = 1'b1;
            dec_qty   = QTY_COOLANT;
            dec_value = $signed({7'd0, byte_a} - COOLANT_OFFSET);
          end
        end
        PID_THROTTLE: begin
          if ((kept_cur >= KEPT_W'(6)) && !bad_a) begin
            dec_ok    = 1'b1;
            dec_qty   = QTY_THROTTLE;
            dec_value = {7'd0, div255(pct_prod)};
          end
        end
        PID_FUEL: begin
          if ((kept_cur >= KEPT_W'(6)) && !bad_a) begin
            dec_ok    = 1'b1;
            dec_qty   = QTY_FUEL;
            dec_value = {7'd0, div255(pct_prod)};
          end
        end
        default: begin
          dec_ok = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    kept_count_nxt   = kept_cur;
    string_ended_nxt = string_ended_r ||
                       (in_acc && !string_ended_r && (in_character == CHAR_NUL));
    out_valid_nxt    = out_valid_r && !out_ready;
    out_ok_nxt       = out_ok_r;
    out_qty_nxt      = out_qty_r;
    out_value_nxt    = out_value_r;
    if (in_acc && in_last_char) begin
      // Emit the result and clear for the next reply.
      kept_count_nxt   = '0;
      string_ended_nxt = 1'b0;
      out_valid_nxt    = 1'b1;
      out_ok_nxt       = dec_ok;
      out_qty_nxt      = dec_qty;
      out_value_nxt    = dec_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= nib;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r    <= out_ok_nxt;
    out_qty_r   <= out_qty_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_count_r   <= '0;
      string_ended_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      kept_count_r   <= kept_count_nxt;
      string_ended_r <= string_ended_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_quantity = out_qty_r;
  assign out_value    = out_value_r;

  `OBD_ASSERT_NOW(a_kept_bound, 1'b1, kept_count_r <= KEPT_W'(STORE_DEPTH))
  `OBD_ASSERT_NEXT(a_last_emits, in_acc && in_last_char, out_valid_r)
  `OBD_ASSERT_NEXT(a_last_clears, in_acc && in_last_char, kept_count_r == '0 && !string_ended_r)
  `OBD_ASSERT_NOW(a_fail_zero, out_valid_r && !out_ok_r, out_qty_r == QTY_RPM && out_value_r == '0)
  `OBD_ASSERT_NOW(a_ended_no_write, string_ended_r, !wr_en)

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import obd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned HOLD_AT      = 450;
  localparam int unsigned RANDOM_CHARS = 925;
  localparam logic [4:0]  NIBBLE_BAD   = 5'h10;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct {
    logic              ok;
    qty_t              quantity;
    logic signed [14:0] value;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_character = 8'h00;
  logic               in_last_char = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [2:0]         out_quantity;
  logic signed [14:0] out_value;

  char_req_t pending_chars[$];
  reading_t  expected_readings[$];

  // Decoder shadow state
  logic [4:0] nibble_mem[8];
  int         kept_chars;
  bit         text_ended;

  int  error_count;
  int  chars_taken;
  bit  req_taken;
  int  burst_left = 1;
  int  gap_left;
  int  hold_left;
  bit  hold_done;
  int  ready_mode;
  int  mode_left;
  int  idle_cycles;

  always #5 clk = ~clk;

  obd_mode01_hex_response_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_character(in_character),
    .in_last_char(in_last_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_quantity(out_quantity),
    .out_value   (out_value)
  );

  function automatic logic [4:0] char_to_nibble(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b0, ch[3:0]};
    if (ch >= 8'h41 && ch <= 8'h46) return {1'b0, 4'(ch - 8'h37)};
    if (ch >= 8'h61 && ch <= 8'h66) return {1'b0, 4'(ch - 8'h57)};
    return NIBBLE_BAD;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CHAR_SPACE;
      1:       return CHAR_CR;
      default: return CHAR_LF;
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CHAR_SPACE || ch == CHAR_CR || ch == CHAR_LF;
  endfunction

  // Byte built from two kept nibbles; -1 when either is not hex.
  function automatic int kept_byte(input int pos);
    logic [4:0] hi;
    logic [4:0] lo;
    hi = nibble_mem[pos];
    lo = nibble_mem[pos + 1];
    if (hi[4] || lo[4]) return -1;
    return int'({hi[3:0], lo[3:0]});
  endfunction

  task automatic track_character(input logic [7:0] ch, input logic last);
    reading_t rd;
    int       mode_byte;
    int       pid_byte;
    int       a;
    int       b;
    if (!text_ended) begin
      if (ch == CHAR_NUL) begin
        text_ended = 1'b1;
      end else if (!is_blank(ch) && kept_chars < 8) begin
        nibble_mem[kept_chars] = char_to_nibble(ch);
        kept_chars++;
      end
    end
    if (!last) return;
    rd.ok = 1'b0;
    rd.quantity = QTY_RPM;
    rd.value = '0;
    if (kept_chars >= 4) begin
      mode_byte = kept_byte(0);
      pid_byte = kept_byte(2);
      if (mode_byte == int'(MODE01_REPLY)) begin
        if (pid_byte == int'(PID_RPM)) begin
          if (kept_chars >= 8) begin
            a = kept_byte(4);
            b = kept_byte(6);
            if (a >= 0 && b >= 0) begin
              rd.ok = 1'b1;
              rd.value = 15'((a * 256 + b) / 4);
            end
          end
        end else if (pid_byte == int'(PID_SPEED) || pid_byte == int'(PID_COOLANT) ||
                     pid_byte == int'(PID_THROTTLE) || pid_byte == int'(PID_FUEL)) begin
          if (kept_chars >= 6) begin
            a = kept_byte(4);
            if (a >= 0) begin
              rd.ok = 1'b1;
              if (pid_byte == int'(PID_SPEED)) begin
                rd.quantity = QTY_SPEED;
                rd.value = 15'(a);
              end else if (pid_byte == int'(PID_COOLANT)) begin
                rd.quantity = QTY_COOLANT;
                rd.value = 15'(a - 40);
              end else begin
                rd.quantity = (pid_byte == int'(PID_THROTTLE)) ? QTY_THROTTLE : QTY_FUEL;
                rd.value = 15'((a * 100) / 255);
              end
            end
          end
        end
      end
    end
    expected_readings.push_back(rd);
    kept_chars = 0;
    text_ended = 1'b0;
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    char_req_t req;
    req.ch = ch;
    req.last = last;
    pending_chars.push_back(req);
  endtask

  task automatic push_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) push_char(s[i], mark_last && i == s.len() - 1);
  endtask

  // Mostly well-formed replies with random content, the rest noise.
  task automatic add_random_reply();
    logic [7:0] frame[$];
    logic [7:0] text[$];
    logic [7:0] pid;
    bit         upper;
    bit         mark_last;
    if ($urandom_range(0, 99) < 78) begin
      case ($urandom_range(0, 5))
        0:       pid = PID_RPM;
        1:       pid = PID_SPEED;
        2:       pid = PID_COOLANT;
        3:       pid = PID_THROTTLE;
        4:       pid = PID_FUEL;
        default: pid = 8'($urandom);
      endcase
      frame.push_back(($urandom_range(0, 99) < 92) ? MODE01_REPLY : 8'($urandom));
      frame.push_back(pid);
      repeat ((pid == PID_RPM) ? 2 : 1) frame.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
      upper = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) text.push_back(blank_char());
      foreach (frame[i]) begin
        text.push_back(hex_char(frame[i][7:4], upper));
        text.push_back(hex_char(frame[i][3:0], upper));
        if ($urandom_range(0, 1)) text.push_back(CHAR_SPACE);
      end
      if ($urandom_range(0, 2) == 0) text.push_back(CHAR_CR);
      // truncate, corrupt or terminate early now and then
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, text.size() - 1)) void'(text.pop_back());
      end
      if ($urandom_range(0, 12) == 0) text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 12) == 0) text.insert($urandom_range(0, text.size() - 1), CHAR_NUL);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        text.push_back(($urandom_range(0, 3) == 0) ? blank_char() : 8'($urandom));
      end
    end
    // drop the end mark now and then so the next reply runs on
    mark_last = $urandom_range(0, 19) != 0;
    foreach (text[i]) push_char(text[i], mark_last && i == text.size() - 1);
  endtask

  // Request monitor and result checker
  always @(posedge clk) begin
    reading_t rd;
    req_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: ok %0d quantity %0d value %0d",
               out_ok, out_quantity, out_value);
        error_count++;
      end else begin
        rd = expected_readings.pop_front();
        if (out_ok !== rd.ok) begin
          $error("ok: expected %0d, actual %0d", rd.ok, out_ok);
          error_count++;
        end
        if (out_quantity !== rd.quantity) begin
          $error("quantity: expected %0d, actual %0d", rd.quantity, out_quantity);
          error_count++;
        end
        if (out_value !== rd.value) begin
          $error("value: expected %0d, actual %0d", rd.value, out_value);
          error_count++;
        end
      end
    end
    if (req_taken) begin
      track_character(in_character, in_last_char);
      chars_taken++;
    end
  end

  // Request driver: bursts with random gaps
  always @(negedge clk) begin
    char_req_t req;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (gap_left > 0 || pending_chars.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        req = pending_chars.pop_front();
        in_character <= req.ch;
        in_last_char <= req.last;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && chars_taken >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
    end else begin
      if (mode_left <= 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("obd_mode01_hex_response_decoder regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    foreach (nibble_mem[i]) nibble_mem[i] = '0;
    kept_chars = 0;
    text_ended = 1'b0;

    // rpm at full scale, coolant at its floor, lowercase throttle at 100 %
    push_text("410CFFFF", 1'b1);
    push_text("410500", 1'b1);
    push_text("4111ff", 1'b1);
    // fuel reply cut short by a zero, junk after it
    push_text("41", 1'b0);
    push_char(CHAR_LF, 1'b0);
    push_text("2F", 1'b0);
    push_char(CHAR_NUL, 1'b0);
    push_text("G", 1'b1);

    while (pending_chars.size() < RANDOM_CHARS) add_random_reply();
    // close any run-on reply so its result is produced
    push_char(CHAR_SPACE, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (expected_readings.size() != 0) begin
      $error("%0d results never arrived", expected_readings.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("obd_mode01_hex_response_decoder regression: pass");
    end else begin
      $display("obd_mode01_hex_response_decoder regression: fail");
    end
    $finish;
  end

endmodule
